// ===== src/scpr_pkg.sv =====
// Shared constants, types and command struct for the second-chance page replacer.
`default_nettype none
package scpr_pkg;

  localparam int unsigned MaxFrames       = 16;
  localparam int unsigned PageBits        = 16;
  localparam int unsigned SlotBits        = 4;
  localparam int unsigned CountBits       = 5;
  localparam int unsigned FaultBits       = 32;
  localparam int unsigned DataBits        = 32;
  localparam int unsigned AddrBits        = 3;
  localparam int unsigned FrameCountReset = 4;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StSweep
  } scpr_state_e;

  // Register index of the frame count, decoded from the word address.
  localparam logic RegFrameCount = 1'b0;

  // Command from the sequencer to the frame store.
  typedef struct packed {
    logic                clr_all;
    logic                ref_set;
    logic                ref_clr;
    logic                page_wr;
    logic [SlotBits-1:0] slot;
  } scpr_cmd_t;

endpackage
`default_nettype wire

// ===== src/second_chance_page_replacer.sv =====
// Top level of the second-chance (clock) page replacer: sequencer, counters and ports.
`default_nettype none
// One request carries a page reference; one result comes back for each request.
// The block works on one request at a time and holds in_ready_o low while busy.
// Set-up is done as a request is accepted (start_new clearing, frame count saturation,
// hand wrap); then the single page comparator walks the resident frames from frame 0.
// A hit finishes on the matching frame. A miss with a free frame fills the next unused
// frame once the walk ends. A miss with all frames full moves to the clock sweep, one
// frame per cycle on the shared reference-bit port, holding on the victim while the
// output register is full: at most n bits are cleared before a clear bit is found and
// replaced, for n active frames.
// The result sits in an output register, so a finished result may wait for
// out_ready_i; the next request is taken only once the sequencer is back to idle.
// The frame count register lies at byte address 0 of the APB-style port; write it
// only while the block is idle. A count of 0 acts as 1, one above 16 acts as 16.
// There is no clearing pass after reset.
module second_chance_page_replacer (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                start_new_i,
  input  wire logic [scpr_pkg::PageBits-1:0]       page_number_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     hit_o,
  output logic      [scpr_pkg::SlotBits-1:0]       frame_slot_o,
  output logic                                     evicted_valid_o,
  output logic      [scpr_pkg::PageBits-1:0]       evicted_page_o,
  output logic      [scpr_pkg::FaultBits-1:0]      fault_count_o,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [scpr_pkg::AddrBits-1:0]       paddr,
  input  wire logic [scpr_pkg::DataBits-1:0]       pwdata,
  output logic      [scpr_pkg::DataBits-1:0]       prdata,
  output logic                                     pready
);

  localparam logic [scpr_pkg::CountBits-1:0] CountOne =
    scpr_pkg::CountBits'(1);
  localparam logic [scpr_pkg::CountBits-1:0] CountMax =
    scpr_pkg::CountBits'(scpr_pkg::MaxFrames);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [scpr_pkg::CountBits-1:0] frame_count_q, frame_count_d;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == scpr_pkg::RegFrameCount);

  always_comb begin
    frame_count_d = frame_count_q;
    if (cfg_wr) begin
      frame_count_d = pwdata[scpr_pkg::CountBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == scpr_pkg::RegFrameCount) begin
      prdata = {{(scpr_pkg::DataBits-scpr_pkg::CountBits){1'b0}}, frame_count_q};
    end
  end

  // Saturate the written count into the active frame count.
  logic [scpr_pkg::CountBits-1:0] eff_count;
  always_comb begin
    eff_count = frame_count_q;
    if (frame_count_q == '0) begin
      eff_count = CountOne;
    end else if (frame_count_q > CountMax) begin
      eff_count = CountMax;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and counters
  // ---------------------------------------------------------------------------
  scpr_pkg::scpr_state_e           state_q, state_d;
  logic [scpr_pkg::PageBits-1:0]   page_q, page_d;
  logic [scpr_pkg::CountBits-1:0]  n_q, n_d;
  logic [scpr_pkg::CountBits-1:0]  idx_q, idx_d;
  logic [scpr_pkg::CountBits-1:0]  used_q, used_d;
  logic [scpr_pkg::SlotBits-1:0]   hand_q, hand_d;
  logic [scpr_pkg::FaultBits-1:0]  faults_q, faults_d;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic                            hit_q, hit_d;
  logic [scpr_pkg::SlotBits-1:0]   slot_q, slot_d;
  logic                            ev_valid_q, ev_valid_d;
  logic [scpr_pkg::PageBits-1:0]   ev_page_q, ev_page_d;
  logic [scpr_pkg::FaultBits-1:0]  fault_out_q, fault_out_d;

  scpr_pkg::scpr_cmd_t             cmd;
  logic [scpr_pkg::PageBits-1:0]   rd_page;
  logic                            rd_ref;
  logic                            match;

  logic [scpr_pkg::CountBits-1:0]  searched;
  logic                            frame_free;
  logic                            out_free;
  logic [scpr_pkg::SlotBits-1:0]   hand_next;
  logic [scpr_pkg::FaultBits-1:0]  faults_inc;

  assign searched   = (used_q < n_q) ? used_q : n_q;
  assign frame_free = (used_q < n_q);
  // The output register may be loaded when empty or drained in this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign hand_next  = (({1'b0, hand_q} + CountOne) == n_q) ? '0 : (hand_q + 1'b1);
  assign faults_inc = (faults_q == '1) ? faults_q : (faults_q + 1'b1);

  scpr_frames u_frames (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .page_i    (page_q),
    .rd_page_o (rd_page),
    .rd_ref_o  (rd_ref),
    .match_o   (match)
  );

  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    n_d         = n_q;
    idx_d       = idx_q;
    used_d      = used_q;
    hand_d      = hand_q;
    faults_d    = faults_q;
    out_valid_d = out_valid_q && !out_ready_i;
    hit_d       = hit_q;
    slot_d      = slot_q;
    ev_valid_d  = ev_valid_q;
    ev_page_d   = ev_page_q;
    fault_out_d = fault_out_q;
    in_ready_o  = 1'b0;
    cmd         = '0;
    cmd.slot    = idx_q[scpr_pkg::SlotBits-1:0];

    case (state_q)
      scpr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          page_d  = page_number_i;
          n_d     = eff_count;
          idx_d   = '0;
          state_d = scpr_pkg::StSearch;
          if (start_new_i) begin
            // Fresh run: drop residency, hand and fault history.
            cmd.clr_all = 1'b1;
            used_d      = '0;
            hand_d      = '0;
            faults_d    = '0;
          end else if ({1'b0, hand_q} >= eff_count) begin
            hand_d = '0;
          end
        end
      end

      scpr_pkg::StSearch: begin
        if (idx_q == searched) begin
          if (frame_free) begin
            // Miss with a free frame: fill the next one.
            cmd.slot = used_q[scpr_pkg::SlotBits-1:0];
            if (out_free) begin
              cmd.page_wr = 1'b1;
              cmd.ref_clr = 1'b1;
              used_d      = used_q + 1'b1;
              hand_d      = hand_next;
              faults_d    = faults_inc;
              out_valid_d = 1'b1;
              hit_d       = 1'b0;
              slot_d      = used_q[scpr_pkg::SlotBits-1:0];
              ev_valid_d  = 1'b0;
              ev_page_d   = '0;
              fault_out_d = faults_inc;
              state_d     = scpr_pkg::StIdle;
            end
          end else begin
            state_d = scpr_pkg::StSweep;
          end
        end else if (match) begin
          if (out_free) begin
            cmd.ref_set = 1'b1;
            out_valid_d = 1'b1;
            hit_d       = 1'b1;
            slot_d      = idx_q[scpr_pkg::SlotBits-1:0];
            ev_valid_d  = 1'b0;
            ev_page_d   = '0;
            fault_out_d = faults_q;
            state_d     = scpr_pkg::StIdle;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      scpr_pkg::StSweep: begin
        cmd.slot = hand_q;
        if (rd_ref) begin
          // Second chance: clear the bit and advance the hand.
          cmd.ref_clr = 1'b1;
          hand_d      = hand_next;
        end else if (out_free) begin
          // Victim found: replace it and advance past it.
          cmd.page_wr = 1'b1;
          cmd.ref_clr = 1'b1;
          hand_d      = hand_next;
          faults_d    = faults_inc;
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          slot_d      = hand_q;
          ev_valid_d  = 1'b1;
          ev_page_d   = rd_page;
          fault_out_d = faults_inc;
          state_d     = scpr_pkg::StIdle;
        end
      end

      default: begin
        state_d = scpr_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= scpr_pkg::StIdle;
      frame_count_q <= scpr_pkg::CountBits'(scpr_pkg::FrameCountReset);
      n_q           <= CountOne;
      idx_q         <= '0;
      used_q        <= '0;
      hand_q        <= '0;
      faults_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      frame_count_q <= frame_count_d;
      n_q           <= n_d;
      idx_q         <= idx_d;
      used_q        <= used_d;
      hand_q        <= hand_d;
      faults_q      <= faults_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    hit_q       <= hit_d;
    slot_q      <= slot_d;
    ev_valid_q  <= ev_valid_d;
    ev_page_q   <= ev_page_d;
    fault_out_q <= fault_out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;

endmodule
`default_nettype wire

// ===== src/scpr_frames.sv =====
// Frame store: page numbers, reference bits and the single shared page comparator.
`default_nettype none
module scpr_frames (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire scpr_pkg::scpr_cmd_t                cmd_i,
  input  wire logic [scpr_pkg::PageBits-1:0]      page_i,
  output logic      [scpr_pkg::PageBits-1:0]      rd_page_o,
  output logic                                    rd_ref_o,
  output logic                                    match_o
);

  logic [scpr_pkg::PageBits-1:0]  pages_q [scpr_pkg::MaxFrames];
  logic [scpr_pkg::MaxFrames-1:0] ref_q;

  // Payload store: no reset, written only on fill or replace.
  always_ff @(posedge clk_i) begin
    if (cmd_i.page_wr) begin
      pages_q[cmd_i.slot] <= page_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
    end else if (cmd_i.clr_all) begin
      ref_q <= '0;
    end else if (cmd_i.ref_set) begin
      ref_q[cmd_i.slot] <= 1'b1;
    end else if (cmd_i.ref_clr) begin
      ref_q[cmd_i.slot] <= 1'b0;
    end
  end

  assign rd_page_o = pages_q[cmd_i.slot];
  assign rd_ref_o  = ref_q[cmd_i.slot];
  assign match_o   = (pages_q[cmd_i.slot] == page_i);

endmodule
`default_nettype wire

// ===== test/scpr_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the second-chance page replacer: mirrors the frame table and compares.
module scpr_result_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                start_new_i,
  input  logic [scpr_pkg::PageBits-1:0]       page_number_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic                                hit_i,
  input  logic [scpr_pkg::SlotBits-1:0]       frame_slot_i,
  input  logic                                evicted_valid_i,
  input  logic [scpr_pkg::PageBits-1:0]       evicted_page_i,
  input  logic [scpr_pkg::FaultBits-1:0]      fault_count_i,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [scpr_pkg::AddrBits-1:0]       paddr,
  input  logic [scpr_pkg::DataBits-1:0]       pwdata,
  output int                                  in_flight_o,
  output int                                  mismatches_o
);

  typedef struct packed {
    logic                             hit;
    logic [scpr_pkg::SlotBits-1:0]    slot;
    logic                             evicted;
    logic [scpr_pkg::PageBits-1:0]    evicted_page;
    logic [scpr_pkg::FaultBits-1:0]   faults;
  } page_outcome_t;

  // Mirror of the block's state.
  logic [scpr_pkg::CountBits-1:0]  frame_count;
  logic [scpr_pkg::PageBits-1:0]   frame_pages [scpr_pkg::MaxFrames];
  logic                            ref_bits    [scpr_pkg::MaxFrames];
  logic [scpr_pkg::CountBits-1:0]  frames_used;
  logic [scpr_pkg::SlotBits-1:0]   clock_hand;
  logic [scpr_pkg::FaultBits-1:0]  faults;

  page_outcome_t expected_outcomes [$];
  page_outcome_t oldest;
  int            mismatch_count = 0;
  int            results_seen = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("[%0t] result %0d mismatch: %s", $time, results_seen, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", field, got, want));
    end
  endtask

  function automatic void clear_frames();
    foreach (frame_pages[i]) begin
      frame_pages[i] = '0;
      ref_bits[i]    = 1'b0;
    end
    frames_used = '0;
    clock_hand  = '0;
    faults      = '0;
  endfunction

  function automatic page_outcome_t predict_reference(input logic start,
                                                      input logic [scpr_pkg::PageBits-1:0] page);
    page_outcome_t res;
    int            n;
    int            searched;
    res = '0;
    if (start) clear_frames();
    n = (frame_count == 0) ? 1 :
        ((frame_count > scpr_pkg::MaxFrames) ? scpr_pkg::MaxFrames : int'(frame_count));
    if (clock_hand >= n) clock_hand = '0;
    searched = (frames_used < n) ? int'(frames_used) : n;
    for (int i = 0; i < searched; i++) begin
      if (!res.hit && frame_pages[i] == page) begin
        ref_bits[i] = 1'b1;
        res.hit     = 1'b1;
        res.slot    = scpr_pkg::SlotBits'(i);
      end
    end
    if (!res.hit) begin
      if (faults != '1) faults++;
      if (frames_used < n) begin
        res.slot = frames_used[scpr_pkg::SlotBits-1:0];
        frame_pages[frames_used[scpr_pkg::SlotBits-1:0]] = page;
        ref_bits[frames_used[scpr_pkg::SlotBits-1:0]]    = 1'b0;
        frames_used++;
      end else begin
        // sweep: clear set bits until a clear one turns up
        while (ref_bits[clock_hand]) begin
          ref_bits[clock_hand] = 1'b0;
          clock_hand = scpr_pkg::SlotBits'((int'(clock_hand) + 1) % n);
        end
        res.slot                = clock_hand;
        res.evicted             = 1'b1;
        res.evicted_page        = frame_pages[clock_hand];
        frame_pages[clock_hand] = page;
        ref_bits[clock_hand]    = 1'b0;
      end
      clock_hand = scpr_pkg::SlotBits'((int'(clock_hand) + 1) % n);
    end
    res.faults = faults;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count = scpr_pkg::CountBits'(scpr_pkg::FrameCountReset);
      clear_frames();
      expected_outcomes.delete();
      in_flight_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[scpr_pkg::AddrBits-1:2] == scpr_pkg::RegFrameCount) begin
        frame_count = pwdata[scpr_pkg::CountBits-1:0];
      end
      if (in_valid_i && in_ready_i) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 predict_reference(start_new_i, page_number_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          oldest = expected_outcomes.pop_front();
          check_field("hit", 32'(hit_i), 32'(oldest.hit));
          check_field("frame_slot", 32'(frame_slot_i), 32'(oldest.slot));
          check_field("evicted_valid", 32'(evicted_valid_i), 32'(oldest.evicted));
          check_field("evicted_page", 32'(evicted_page_i), 32'(oldest.evicted_page));
          check_field("fault_count", fault_count_i, oldest.faults);
        end
        results_seen++;
      end
      in_flight_o <= expected_outcomes.size();
    end
  end

endmodule

// ===== test/second_chance_page_replacer_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the second-chance page replacer: stimulus, idling, watchdog and verdict.
module second_chance_page_replacer_test;

  // Cycles with no accepted request, result or register write before the run is abandoned.
  localparam int StallLimit = 2000;
  localparam int Phases     = 10;
  localparam int PhaseItems = 68;
  localparam int TailCycles = 40;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic                               start_new_i;
  logic [scpr_pkg::PageBits-1:0]      page_number_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic                               hit_o;
  logic [scpr_pkg::SlotBits-1:0]      frame_slot_o;
  logic                               evicted_valid_o;
  logic [scpr_pkg::PageBits-1:0]      evicted_page_o;
  logic [scpr_pkg::FaultBits-1:0]     fault_count_o;
  logic                               psel;
  logic                               penable;
  logic                               pwrite;
  logic [scpr_pkg::AddrBits-1:0]      paddr;
  logic [scpr_pkg::DataBits-1:0]      pwdata;
  logic [scpr_pkg::DataBits-1:0]      prdata;
  logic                               pready;

  int in_flight;
  int mismatches;
  int idle_cycles = 0;
  // When set, the matching side runs flat out for the whole phase.
  bit steady_in  = 1'b0;
  bit steady_out = 1'b0;

  second_chance_page_replacer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_new_i     (start_new_i),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // The checker sees both channels and the register port, so it tracks the frame count itself.
  scpr_result_checker result_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .start_new_i     (start_new_i),
    .page_number_i   (page_number_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_i           (hit_o),
    .frame_slot_i    (frame_slot_o),
    .evicted_valid_i (evicted_valid_o),
    .evicted_page_i  (evicted_page_o),
    .fault_count_i   (fault_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_flight_o     (in_flight),
    .mismatches_o    (mismatches)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until accepted. With no gap the next request replaces
  // the accepted one in the same step, so valid is never dropped and raised in one step.
  task automatic send_request(input logic start, input logic [scpr_pkg::PageBits-1:0] page);
    int unsigned gap;
    gap = idle_gap(steady_in);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_new_i   <= start;
    page_number_i <= page;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait until every result is back, then write the frame count register
  // with a setup phase and then an access phase.
  task automatic set_frame_count(input logic [scpr_pkg::DataBits-1:0] word);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {scpr_pkg::RegFrameCount, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: bursts of ready, broken by stalls of random length.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (steady_out || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat (idle_gap(1'b0)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any accepted request, result or register write restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("second_chance_page_replacer_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned                   count;
    int unsigned                   n_eff;
    int unsigned                   hot_count;
    int unsigned                   r;
    logic [scpr_pkg::PageBits-1:0] hot_pages [20];
    logic [scpr_pkg::DataBits-1:0] word;
    logic                          start;
    logic [scpr_pkg::PageBits-1:0] page;

    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    start_new_i   <= 1'b0;
    page_number_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset frame count of four: fill with the page extremes, set two reference bits,
    // then miss so the sweep clears both bits and replaces the third frame.
    send_request(1'b1, 16'h0000);
    send_request(1'b0, 16'hFFFF);
    send_request(1'b0, 16'h5555);
    send_request(1'b0, 16'hAAAA);
    send_request(1'b0, 16'h0000);
    send_request(1'b0, 16'hFFFF);
    send_request(1'b0, 16'h0001);
    send_request(1'b0, 16'h0001);

    // Lower the count to two while four frames are used: the hand sits beyond the count
    // and wraps, and pages above the count are out of reach.
    set_frame_count(32'd2);
    send_request(1'b0, 16'h7777);
    send_request(1'b0, 16'hAAAA);
    send_request(1'b0, 16'h7777);

    // Raise it again: the hidden frames come back with their old pages.
    set_frame_count(32'd4);
    send_request(1'b0, 16'hAAAA);
    send_request(1'b0, 16'h0001);

    // A count of zero behaves as one; upper word bits set and ignored.
    set_frame_count(32'hFFFF_FFE0);
    send_request(1'b1, 16'h1234);
    send_request(1'b0, 16'h1234);
    send_request(1'b0, 16'h4321);
    send_request(1'b0, 16'hFFFF);

    // Largest field value: saturates to the built frame count.
    set_frame_count(32'h0000_001F);
    send_request(1'b1, 16'h8000);
    send_request(1'b0, 16'h0000);
    send_request(1'b0, 16'h8000);

    // Random phases: each picks a frame count and a hot set of the active frames plus up
    // to three, so hits, fills and sweeps all occur; a few requests restart the
    // run, swap a hot page out, or reference a cold page.
    for (int ph = 0; ph < Phases; ph++) begin
      case ($urandom_range(0, 7))
        0:       count = 0;
        1:       count = 1;
        2:       count = scpr_pkg::MaxFrames;
        3:       count = $urandom_range(scpr_pkg::MaxFrames + 1, 31);
        default: count = $urandom_range(2, scpr_pkg::MaxFrames - 1);
      endcase
      word = ($urandom_range(0, 3) == 0) ? $urandom : '0;
      word[scpr_pkg::CountBits-1:0] = count[scpr_pkg::CountBits-1:0];
      set_frame_count(word);

      n_eff = (count == 0) ? 1 : ((count > scpr_pkg::MaxFrames) ? scpr_pkg::MaxFrames : count);
      hot_count = n_eff + $urandom_range(0, 3);
      foreach (hot_pages[i]) hot_pages[i] = scpr_pkg::PageBits'($urandom);
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < PhaseItems; k++) begin
        r     = $urandom_range(0, 99);
        start = (r < 3);
        if (r < 85) begin
          page = hot_pages[$urandom_range(0, hot_count - 1)];
        end else if (r < 92) begin
          page = scpr_pkg::PageBits'($urandom);
          hot_pages[$urandom_range(0, hot_count - 1)] = page;
        end else begin
          page = scpr_pkg::PageBits'($urandom);
        end
        send_request(start, page);
      end
    end

    // Drain, then allow a worst-case request time for any stray result to show up.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("second_chance_page_replacer_test: done, clean");
    end else begin
      $display("second_chance_page_replacer_test: done, errors");
    end
    $finish;
  end

endmodule
